// ----- hdl/hbs_pkg.sv -----
// Shared types, widths and helper functions for the heightmap bilinear sampler.
// Used by the top level and its front and back parts; depends on nothing else.
package hbs_pkg;

  localparam int MAX_DIM_DEF = 256;

  localparam int SIZE_W  = 9;
  localparam int INV_W   = 16;
  localparam int POS_W   = 20;
  localparam int HGT_W   = 16;
  localparam int ADDR_W  = 16;
  localparam int CELL_W  = 9;
  localparam int FRAC_W  = 8;
  localparam int LOCAL_W = CELL_W + FRAC_W;
  localparam int PROD_W  = POS_W + INV_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_DEPTH  = 2'd1,
    CFG_INV_SPACING = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } act_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] depth;
    logic [INV_W-1:0]  inv;
  } cfg_t;

  typedef struct packed {
    act_t                     action;
    logic [ADDR_W-1:0]        cell_index;
    logic signed [HGT_W-1:0]  height_value;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_z;
  } mid_item_t;

  // A size of zero acts as one; a size above the grid limit saturates to it.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                 input int max_dim);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (int'(s) > max_dim) begin
      r = SIZE_W'(max_dim);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ----- hdl/heightmap_bilinear_sampler.sv -----
// Top level of the heightmap bilinear sampler: configuration registers, front
// and back parts and the result queue. Depends on hbs_pkg, hbs_front,
// hbs_back and hbs_fifo.
//
//   Channel   Handshake              Payload
//   input     push / full            action, cell_index, height_value, pos_x, pos_z
//   result    empty / pop            height_out
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while full is low. The rate is set by the two
// copies of the grid memory, each read at two addresses per cycle. Full rises
// when the four-entry queue between the parts is full; queries wait there while
// eight results are outstanding. Reset clears control state only; grid entries
// hold nothing until written.
module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        action,
  input  logic [ADDR_W-1:0]           cell_index,
  input  logic signed [HGT_W-1:0]     height_value,
  input  logic signed [POS_W-1:0]     pos_x,
  input  logic signed [POS_W-1:0]     pos_z,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [HGT_W-1:0]     height_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  cfg_t                    cfg;
  mid_item_t               mid_item;
  logic                    mid_empty;
  logic                    mid_pop;
  logic                    out_push;
  logic signed [HGT_W-1:0] out_height;
  logic                    out_full;
  logic                    out_taken;
  logic [HGT_W-1:0]        out_rdata;

  assign cfg_ready = 1'b1;

  // Grid sizes are kept already limited to the range the sampler can use.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= eff_size(SIZE_W'(256), MAX_DIM);
      cfg.depth <= eff_size(SIZE_W'(256), MAX_DIM);
      cfg.inv   <= INV_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  cfg.width <= eff_size(cfg_data[SIZE_W-1:0], MAX_DIM);
        CFG_GRID_DEPTH:  cfg.depth <= eff_size(cfg_data[SIZE_W-1:0], MAX_DIM);
        CFG_INV_SPACING: cfg.inv   <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  hbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .action      (action),
    .cell_index  (cell_index),
    .height_value(height_value),
    .pos_x       (pos_x),
    .pos_z       (pos_z),
    .mid_pop     (mid_pop),
    .mid_item    (mid_item),
    .mid_empty   (mid_empty)
  );

  hbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_item  (mid_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_push  (out_push),
    .out_height(out_height),
    .out_taken (out_taken)
  );

  assign out_taken = pop && !empty;

  hbs_fifo #(
    .WIDTH(HGT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push && !out_full),
    .wdata(out_height),
    .full (out_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign height_out = $signed(out_rdata);

endmodule

// ----- hdl/hbs_fifo.sv -----
// Small first-in first-out queue built from registers, used between the parts
// of the heightmap sampler and for its results. No package dependency.
module hbs_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/hbs_front.sv -----
// Front part of the heightmap sampler: takes items, scales query positions by
// the inverse cell spacing and queues them. Depends on hbs_pkg and hbs_fifo.
module hbs_front
  import hbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    push,
  output logic                    full,
  input  logic                    action,
  input  logic [ADDR_W-1:0]       cell_index,
  input  logic signed [HGT_W-1:0] height_value,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    mid_pop,
  output mid_item_t               mid_item,
  output logic                    mid_empty
);

  mid_item_t                 item_in;
  logic signed [INV_W:0]     inv_s;
  logic [$bits(mid_item_t)-1:0] q_rdata;

  assign inv_s = $signed({1'b0, cfg.inv});

  always_comb begin
    item_in.action       = act_t'(action);
    item_in.cell_index   = cell_index;
    item_in.height_value = height_value;
    item_in.prod_x       = pos_x * inv_s;
    item_in.prod_z       = pos_z * inv_s;
  end

  hbs_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(item_in),
    .full (full),
    .pop  (mid_pop),
    .rdata(q_rdata),
    .empty(mid_empty)
  );

  assign mid_item = mid_item_t'(q_rdata);

endmodule

// ----- hdl/hbs_back.sv -----
// Back part of the heightmap sampler: maps positions to cells, reads the grid
// and interpolates. Holds the height grid. Depends on hbs_pkg.
module hbs_back
  import hbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  mid_item_t               mid_item,
  input  logic                    mid_empty,
  output logic                    mid_pop,
  output logic                    out_push,
  output logic signed [HGT_W-1:0] out_height,
  input  logic                    out_taken
);

  localparam int CRED_W = $clog2(OUT_DEPTH + 1);
  localparam int GRID_N = 1 << ADDR_W;

  function automatic logic [LOCAL_W-1:0] to_local(input logic signed [PROD_W-1:0] prod,
                                                  input logic [SIZE_W-1:0] size);
    logic signed [PROD_W-1:0] sh;
    logic signed [PROD_W-1:0] off;
    logic signed [PROD_W-1:0] v;
    logic [LOCAL_W-1:0]       top;
    logic [LOCAL_W-1:0]       r;
    top = {size - SIZE_W'(1), {FRAC_W{1'b0}}};
    sh  = prod >>> FRAC_W;
    off = $signed(PROD_W'({size - SIZE_W'(1), {(FRAC_W - 1){1'b0}}}));
    v   = sh + off;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(PROD_W'(top))) begin
      r = top;
    end else begin
      r = v[LOCAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [HGT_W-1:0] lerp(input logic signed [HGT_W-1:0] a,
                                                   input logic signed [HGT_W-1:0] b,
                                                   input logic [FRAC_W-1:0] f);
    logic signed [HGT_W:0]            d;
    logic signed [HGT_W+FRAC_W+1:0]   p;
    logic signed [HGT_W+1:0]          s;
    d = (HGT_W + 1)'(b) - (HGT_W + 1)'(a);
    p = d * $signed({1'b0, f});
    s = (HGT_W + 2)'(a) + (HGT_W + 2)'(p >>> FRAC_W);
    return s[HGT_W-1:0];
  endfunction

  logic [CRED_W-1:0] reserved;
  logic              issue_query;

  logic [LOCAL_W-1:0] loc_x;
  logic [LOCAL_W-1:0] loc_z;
  logic [CELL_W-1:0]  cx0;
  logic [CELL_W-1:0]  cz0;

  logic                    a_valid;
  act_t                    a_action;
  logic [ADDR_W-1:0]       a_waddr;
  logic signed [HGT_W-1:0] a_wdata;
  logic [CELL_W-1:0]       a_x0;
  logic [CELL_W-1:0]       a_x1;
  logic [CELL_W-1:0]       a_z0;
  logic [CELL_W-1:0]       a_z1;
  logic [FRAC_W-1:0]       a_fx;
  logic [FRAC_W-1:0]       a_fz;

  logic [2*CELL_W-1:0] row0_full;
  logic [2*CELL_W-1:0] row1_full;

  logic                    b_valid;
  act_t                    b_action;
  logic [ADDR_W-1:0]       b_waddr;
  logic signed [HGT_W-1:0] b_wdata;
  logic [CELL_W-1:0]       b_x0;
  logic [CELL_W-1:0]       b_x1;
  logic [ADDR_W-1:0]       b_row0;
  logic [ADDR_W-1:0]       b_row1;
  logic [FRAC_W-1:0]       b_fx;
  logic [FRAC_W-1:0]       b_fz;

  logic [ADDR_W-1:0] addr00;
  logic [ADDR_W-1:0] addr10;
  logic [ADDR_W-1:0] addr01;
  logic [ADDR_W-1:0] addr11;
  logic              grid_we;

  logic signed [HGT_W-1:0] grid_lo [GRID_N];
  logic signed [HGT_W-1:0] grid_hi [GRID_N];

  logic                    c_valid;
  logic signed [HGT_W-1:0] c_h00;
  logic signed [HGT_W-1:0] c_h10;
  logic signed [HGT_W-1:0] c_h01;
  logic signed [HGT_W-1:0] c_h11;
  logic [FRAC_W-1:0]       c_fx;
  logic [FRAC_W-1:0]       c_fz;

  logic                    d_valid;
  logic signed [HGT_W-1:0] d_h0;
  logic signed [HGT_W-1:0] d_h1;
  logic [FRAC_W-1:0]       d_fz;

  // A query enters only when the result queue is sure to have room for it.
  assign mid_pop = !mid_empty &&
                   (mid_item.action == ACT_WRITE || reserved < CRED_W'(OUT_DEPTH));
  assign issue_query = mid_pop && (mid_item.action == ACT_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if (issue_query && !out_taken) begin
      reserved <= reserved + CRED_W'(1);
    end else if (!issue_query && out_taken) begin
      reserved <= reserved - CRED_W'(1);
    end
  end

  always_comb begin
    loc_x = to_local(mid_item.prod_x, cfg.width);
    loc_z = to_local(mid_item.prod_z, cfg.depth);
    cx0   = loc_x[LOCAL_W-1:FRAC_W];
    cz0   = loc_z[LOCAL_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    a_action <= mid_item.action;
    a_waddr  <= mid_item.cell_index;
    a_wdata  <= mid_item.height_value;
    a_x0     <= cx0;
    a_z0     <= cz0;
    a_x1     <= (cx0 < cfg.width - SIZE_W'(1)) ? cx0 + CELL_W'(1) : cx0;
    a_z1     <= (cz0 < cfg.depth - SIZE_W'(1)) ? cz0 + CELL_W'(1) : cz0;
    a_fx     <= loc_x[FRAC_W-1:0];
    a_fz     <= loc_z[FRAC_W-1:0];
  end

  always_comb begin
    row0_full = a_z0 * cfg.width;
    row1_full = a_z1 * cfg.width;
  end

  always_ff @(posedge clk) begin
    b_action <= a_action;
    b_waddr  <= a_waddr;
    b_wdata  <= a_wdata;
    b_x0     <= a_x0;
    b_x1     <= a_x1;
    b_row0   <= row0_full[ADDR_W-1:0];
    b_row1   <= row1_full[ADDR_W-1:0];
    b_fx     <= a_fx;
    b_fz     <= a_fz;
  end

  always_comb begin
    addr00  = b_row0 + ADDR_W'(b_x0);
    addr10  = b_row0 + ADDR_W'(b_x1);
    addr01  = b_row1 + ADDR_W'(b_x0);
    addr11  = b_row1 + ADDR_W'(b_x1);
    grid_we = b_valid && (b_action == ACT_WRITE);
  end

  // Two copies of the grid, each with two read ports, serve the four corners.
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_lo[b_waddr] <= b_wdata;
    end
    c_h00 <= grid_lo[addr00];
    c_h10 <= grid_lo[addr10];
  end

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_hi[b_waddr] <= b_wdata;
    end
    c_h01 <= grid_hi[addr01];
    c_h11 <= grid_hi[addr11];
  end

  always_ff @(posedge clk) begin
    c_fx <= b_fx;
    c_fz <= b_fz;
    d_h0 <= lerp(c_h00, c_h10, c_fx);
    d_h1 <= lerp(c_h01, c_h11, c_fx);
    d_fz <= c_fz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      a_valid <= mid_pop;
      b_valid <= a_valid;
      c_valid <= b_valid && (b_action == ACT_QUERY);
      d_valid <= c_valid;
    end
  end

  assign out_push   = d_valid;
  assign out_height = lerp(d_h0, d_h1, d_fz);

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for heightmap_bilinear_sampler: directed table, then random
// grid writes and height queries under several grid settings, checked against a predictor.
// Depends on hbs_pkg and the heightmap_bilinear_sampler RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int GRID_ENTRIES = 1 << ADDR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;

  typedef struct packed {
    act_t                    act;
    logic [ADDR_W-1:0]       idx;
    logic signed [HGT_W-1:0] hgt;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] pz;
    logic                    known;
    logic signed [HGT_W-1:0] want;
  } probe_t;

  typedef struct {
    logic [3:0][ADDR_W-1:0] addr;
    int                     fx;
    int                     fz;
  } cell_footprint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  act_t action = ACT_WRITE;
  logic [ADDR_W-1:0] cell_index = '0;
  logic signed [HGT_W-1:0] height_value = '0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [HGT_W-1:0] height_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [HGT_W-1:0] terrain [GRID_ENTRIES];
  bit loaded [GRID_ENTRIES];
  logic [SIZE_W-1:0] reg_width = 9'd256;
  logic [SIZE_W-1:0] reg_depth = 9'd256;
  logic [INV_W-1:0] reg_inv = 16'd256;
  logic signed [HGT_W-1:0] heights_due [$];

  int mismatches = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int settings_run = 0;
  int send_gap_pct = 32;
  int take_gap_pct = 32;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  probe_t probes [15] = '{
    '{ACT_WRITE, 16'd0, 16'sh7FFF, 20'sd0, 20'sd0, 1'b0, 16'sd0},
    '{ACT_WRITE, 16'd1, 16'sh8000, 20'shFFFFF, 20'shFFFFF, 1'b0, 16'sd0},
    '{ACT_WRITE, 16'd256, 16'sh0000, 20'sd0, 20'sd0, 1'b0, 16'sd0},
    '{ACT_WRITE, 16'd257, 16'sh0100, 20'sd0, 20'sd0, 1'b0, 16'sd0},
    '{ACT_WRITE, 16'hFFFF, 16'sh1234, 20'sd0, 20'sd0, 1'b0, 16'sd0},
    '{ACT_QUERY, 16'd0, 16'sh0000, POS_MIN, POS_MIN, 1'b1, 16'sh7FFF},
    '{ACT_QUERY, 16'd0, 16'sh0000, POS_MAX, POS_MAX, 1'b1, 16'sh1234},
    '{ACT_QUERY, 16'd0, 16'sh0000, -20'sd32512, -20'sd32640, 1'b1, 16'shFFFF},
    '{ACT_QUERY, 16'hFFFF, 16'sh8000, -20'sd32640, -20'sd32384, 1'b1, 16'sh0000},
    '{ACT_QUERY, 16'd0, 16'sh0000, -20'sd32384, -20'sd32640, 1'b1, 16'sh8000},
    '{ACT_QUERY, 16'd0, 16'sh0000, 20'sd0, 20'sd0, 1'b0, 16'sd0},
    '{ACT_QUERY, 16'd0, 16'sh0000, -20'sd32555, -20'sd32470, 1'b0, 16'sd0},
    '{ACT_WRITE, 16'd1, 16'sh0ABC, 20'sd12345, -20'sd777, 1'b0, 16'sd0},
    '{ACT_QUERY, 16'd0, 16'sh0000, -20'sd32384, -20'sd32640, 1'b1, 16'sh0ABC},
    '{ACT_QUERY, 16'd0, 16'sh0000, POS_MAX, POS_MIN, 1'b0, 16'sd0}
  };

  heightmap_bilinear_sampler dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(s);
  endfunction

  function automatic longint grid_coord(input logic signed [POS_W-1:0] pos, input int size);
    longint top;
    longint v;
    top = longint'(size - 1) * 256;
    v = ((longint'(pos) * longint'(reg_inv)) >>> 8) + longint'(size - 1) * 128;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic cell_footprint_t footprint(input logic signed [POS_W-1:0] px, pz);
    cell_footprint_t fp;
    int w, d, x0, z0, x1, z1;
    longint lx, lz;
    w = clamp_size(reg_width);
    d = clamp_size(reg_depth);
    lx = grid_coord(px, w);
    lz = grid_coord(pz, d);
    x0 = int'(lx >>> 8);
    z0 = int'(lz >>> 8);
    fp.fx = int'(lx & 255);
    fp.fz = int'(lz & 255);
    x1 = (x0 < w - 1) ? x0 + 1 : x0;
    z1 = (z0 < d - 1) ? z0 + 1 : z0;
    fp.addr[0] = ADDR_W'(z0 * w + x0);
    fp.addr[1] = ADDR_W'(z0 * w + x1);
    fp.addr[2] = ADDR_W'(z1 * w + x0);
    fp.addr[3] = ADDR_W'(z1 * w + x1);
    return fp;
  endfunction

  function automatic longint blend(input longint a, b, input int f);
    return a + ((longint'(f) * (b - a)) >>> 8);
  endfunction

  function automatic logic signed [HGT_W-1:0] expected_height(
      input logic signed [POS_W-1:0] px, pz);
    cell_footprint_t fp;
    longint near_row, far_row;
    fp = footprint(px, pz);
    near_row = blend(terrain[fp.addr[0]], terrain[fp.addr[1]], fp.fx);
    far_row = blend(terrain[fp.addr[2]], terrain[fp.addr[3]], fp.fx);
    return HGT_W'(blend(near_row, far_row, fp.fz));
  endfunction

  function automatic logic signed [HGT_W-1:0] random_height();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return HGT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] random_pos(input int size);
    longint target, p;
    if (reg_inv == '0 || $urandom_range(4) == 0) return POS_W'($urandom);
    target = longint'($urandom_range((size - 1) * 256 + 128)) - 64 - longint'(size - 1) * 128;
    p = (target * 256) / longint'(reg_inv);
    if (p > 524287) p = 524287;
    if (p < -524288) p = -524288;
    return POS_W'(p);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic offer(input act_t act, input logic [ADDR_W-1:0] idx,
                       input logic signed [HGT_W-1:0] hgt, input logic signed [POS_W-1:0] px, pz,
                       input bit known, input logic signed [HGT_W-1:0] want);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    action <= act;
    cell_index <= idx;
    height_value <= hgt;
    pos_x <= px;
    pos_z <= pz;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (act == ACT_WRITE) begin
      terrain[idx] = hgt;
    end else begin
      heights_due.insert(heights_due.size(), known ? want : expected_height(px, pz));
      queries_sent++;
    end
    @(negedge clk);
  endtask

  task automatic write_cell(input logic [ADDR_W-1:0] idx, input logic signed [HGT_W-1:0] hgt);
    loaded[idx] = 1'b1;
    offer(ACT_WRITE, idx, hgt, POS_W'($urandom), POS_W'($urandom), 1'b0, '0);
  endtask

  // Every entry a query reads is loaded first, so no query reads an unwritten entry.
  task automatic query(input logic signed [POS_W-1:0] px, pz, input logic [ADDR_W-1:0] idx,
                       input logic signed [HGT_W-1:0] hgt, input bit known,
                       input logic signed [HGT_W-1:0] want);
    cell_footprint_t fp;
    fp = footprint(px, pz);
    for (int i = 0; i < 4; i++) begin
      if (!loaded[fp.addr[i]]) write_cell(fp.addr[i], random_height());
    end
    offer(ACT_QUERY, idx, hgt, px, pz, known, want);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (heights_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GRID_WIDTH: reg_width = val[SIZE_W-1:0];
      CFG_GRID_DEPTH: reg_depth = val[SIZE_W-1:0];
      CFG_INV_SPACING: reg_inv = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] w, d, input logic [INV_W-1:0] inv,
                           input int n_items, input int gap_pct, input bit stray_write,
                           input int hold_at);
    int start, r, gw, gd;
    bit asked;
    wait_idle();
    set_reg(CFG_GRID_WIDTH, {7'($urandom), w});
    set_reg(CFG_GRID_DEPTH, {7'($urandom), d});
    set_reg(CFG_INV_SPACING, inv);
    if (stray_write) set_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_run++;
    send_gap_pct = gap_pct;
    take_gap_pct = gap_pct;
    gw = clamp_size(reg_width);
    gd = clamp_size(reg_depth);
    start = items_sent;
    asked = 1'b0;
    while (items_sent - start < n_items) begin
      if (!asked && hold_at >= 0 && items_sent - start >= hold_at) begin
        asked = 1'b1;
        holds_asked++;
      end
      r = $urandom_range(99);
      if (r < 55) begin
        query(random_pos(gw), random_pos(gd), ADDR_W'($urandom), HGT_W'($urandom), 1'b0, '0);
      end else if (r < 90) begin
        write_cell(ADDR_W'($urandom_range(gd - 1) * gw + $urandom_range(gw - 1)),
                   random_height());
      end else begin
        write_cell(ADDR_W'($urandom), random_height());
      end
    end
  endtask

  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = HOLDOFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [HGT_W-1:0] want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (heights_due.size() == 0) begin
        flag_mismatch($sformatf("height_out %0d arrived with no query pending", height_out));
      end else begin
        want = heights_due.pop_front();
        if (height_out !== want) begin
          flag_mismatch($sformatf("height_out %0d, expected %0d (result %0d)",
                                  height_out, want, results_seen));
        end
      end
    end
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
               quiet_cycles, heights_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (probes[i]) begin
      if (probes[i].act == ACT_WRITE) begin
        loaded[probes[i].idx] = 1'b1;
        offer(ACT_WRITE, probes[i].idx, probes[i].hgt, probes[i].px, probes[i].pz, 1'b0, '0);
      end else begin
        query(probes[i].px, probes[i].pz, probes[i].idx, probes[i].hgt, probes[i].known,
              probes[i].want);
      end
    end
    run_phase(9'd4, 9'd4, 16'd256, 110, 32, 1'b0, 40);
    run_phase(9'd1, 9'd1, 16'hFFFF, 60, 0, 1'b0, -1);
    run_phase(9'd0, 9'd0, 16'd1, 60, 32, 1'b1, -1);
    run_phase(9'h1FF, 9'd300, 16'd512, 100, 32, 1'b0, -1);
    run_phase(9'd8, 9'd3, 16'd0, 60, 32, 1'b0, -1);
    run_phase(9'd256, 9'd2, 16'd128, 80, 32, 1'b0, -1);
    run_phase(9'd3, 9'd256, 16'($urandom_range(1, 65535)), 80, 32, 1'b0, -1);
    repeat (5) begin
      run_phase(9'($urandom_range(2, 16)), 9'($urandom_range(2, 16)),
                16'($urandom_range(1, 2048)), 90, 32, 1'b1, -1);
    end
    run_phase(9'd256, 9'd256, 16'd256, 60, 32, 1'b0, -1);
    wait_idle();
    $display("Run covered %0d items (%0d height queries) and %0d register writes",
             items_sent, queries_sent, cfg_writes);
    $display("over %0d grid settings; %0d heights compared, %0d mismatches.",
             settings_run + 1, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
